/* sv/art_pkg.sv */
// Package for the retransmission tracker: table sizing, entry layout,
// op codes, result kinds and register indexes. No dependencies.
package art_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W       = 16;
    localparam int TRIES_W    = 4;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd250;
    localparam logic [TRIES_W-1:0]   RETRIES_RESET = 4'd3;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_CONFIRM = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED  = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_MATCHED   = 3'd2,
        KIND_UNMATCHED = 3'd3,
        KIND_RESEND    = 3'd4,
        KIND_SCAN_OK   = 3'd5,
        KIND_FAILED    = 3'd6
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_RETRIES = 2'd1
    } reg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TRIES_W-1:0] tries;
        logic [TIME_W-1:0]  deadline;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/art_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/ack_retransmit_tracker.sv */
// Retransmission timeout tracker: entry table in one art_ram, uses art_pkg.
// Send, or confirm/tick on an empty table: result via S_EMIT, held there by output stalls.
// Confirm/tick: S_RD and S_CHK per entry examined, S_SH_WAIT and S_SH_WR per entry moved up
// on removal, plus output stalls; a new word is accepted only back in S_IDLE.
// Reset: table empty, id and time zero, timeout 250, retries 3; RAM needs no clear.
module ack_retransmit_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      opcode,
    input  logic [art_pkg::ID_W-1:0]        ref_id,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      kind,
    output logic [art_pkg::ID_W-1:0]        msg_id,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [art_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [art_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = art_pkg::TABLE_DEPTH;
    localparam int IDX_W = art_pkg::IDX_W;
    localparam int CNT_W = art_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_EMIT,
        S_SH_WAIT,
        S_SH_WR
    } state_t;

    state_t                          state_reg;
    logic                            tick_reg;
    logic [art_pkg::ID_W-1:0]        ref_reg;
    logic [CNT_W-1:0]                used_reg;
    logic [CNT_W-1:0]                idx_reg;
    logic [IDX_W-1:0]                addr_reg;
    logic [art_pkg::ID_W-1:0]        next_id_reg;
    logic [art_pkg::TIME_W-1:0]      time_reg;
    logic [art_pkg::TIMEOUT_W-1:0]   timeout_reg;
    logic [art_pkg::TRIES_W-1:0]     retries_reg;
    art_pkg::kind_t                  pend_kind_reg;
    logic [art_pkg::ID_W-1:0]        pend_id_reg;
    logic                            out_valid_reg;
    art_pkg::kind_t                  kind_reg;
    logic [art_pkg::ID_W-1:0]        msg_id_reg;
    logic                            last_reg;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    art_pkg::entry_t                 ram_wdata;
    logic [art_pkg::ENTRY_W-1:0]     ram_rdata;
    art_pkg::entry_t                 rd;

    logic                            in_acc;
    logic                            can_emit;
    logic                            out_load;
    logic                            full;
    logic [art_pkg::TIME_W:0]        dl_sum;
    logic [art_pkg::TIME_W-1:0]      dl_new;
    logic [CNT_W:0]                  idx_p1;
    logic [CNT_W:0]                  idx_p2;
    logic [CNT_W:0]                  used_x;
    logic                            expired;
    logic                            hit;

    art_ram #(
        .WIDTH (art_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd        = art_pkg::entry_t'(ram_rdata);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign can_emit  = !out_valid_reg || out_ready;
    assign out_load  = can_emit
                       && (((state_reg == S_CHK)
                            && ((!tick_reg && hit) || (tick_reg && expired)))
                           || (state_reg == S_EMIT));
    assign full      = (used_reg == CNT_W'(DEPTH));
    assign dl_sum    = {1'b0, time_reg} + (art_pkg::TIME_W + 1)'(timeout_reg);
    assign dl_new    = dl_sum[art_pkg::TIME_W] ? '1 : dl_sum[art_pkg::TIME_W-1:0];
    assign idx_p1    = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign idx_p2    = {1'b0, idx_reg} + (CNT_W + 1)'(2);
    assign used_x    = {1'b0, used_reg};
    assign expired   = (rd.deadline < time_reg);
    assign hit       = (rd.id == ref_reg);

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign msg_id    = msg_id_reg;
    assign last      = last_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = rd;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (art_pkg::op_t'(opcode) == art_pkg::OP_SEND) && !full)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = used_reg[IDX_W-1:0];
                    ram_wdata = '{id: next_id_reg, tries: retries_reg, deadline: dl_new};
                end
            end
            S_CHK:
            begin
                if (tick_reg && expired && (rd.tries != '0) && can_emit)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{id: rd.id, tries: rd.tries - 1'b1, deadline: dl_new};
                end
            end
            S_SH_WR:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= 1'b0;
            ref_reg       <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            addr_reg      <= '0;
            next_id_reg   <= '0;
            time_reg      <= '0;
            timeout_reg   <= art_pkg::TIMEOUT_RESET;
            retries_reg   <= art_pkg::RETRIES_RESET;
            pend_kind_reg <= art_pkg::KIND_ACCEPTED;
            pend_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= art_pkg::KIND_ACCEPTED;
            msg_id_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (art_pkg::reg_idx_t'(cfg_index))
                    art_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                    art_pkg::REG_RETRIES: retries_reg <= cfg_data[art_pkg::TRIES_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        idx_reg  <= '0;
                        addr_reg <= '0;
                        unique case (art_pkg::op_t'(opcode))
                            art_pkg::OP_SEND:
                            begin
                                pend_id_reg <= next_id_reg;
                                state_reg   <= S_EMIT;
                                if (full)
                                begin
                                    pend_kind_reg <= art_pkg::KIND_FULL;
                                end
                                else
                                begin
                                    pend_kind_reg <= art_pkg::KIND_ACCEPTED;
                                    next_id_reg   <= next_id_reg + 1'b1;
                                    used_reg      <= used_reg + 1'b1;
                                end
                            end
                            art_pkg::OP_CONFIRM:
                            begin
                                tick_reg    <= 1'b0;
                                ref_reg     <= ref_id;
                                pend_id_reg <= ref_id;
                                if (used_reg == '0)
                                begin
                                    pend_kind_reg <= art_pkg::KIND_UNMATCHED;
                                    state_reg     <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            art_pkg::OP_TICK:
                            begin
                                tick_reg <= 1'b1;
                                if (time_reg != '1)
                                begin
                                    time_reg <= time_reg + 1'b1;
                                end
                                pend_id_reg <= '0;
                                if (used_reg == '0)
                                begin
                                    pend_kind_reg <= art_pkg::KIND_SCAN_OK;
                                    state_reg     <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if ((!tick_reg && hit) || (tick_reg && expired && (rd.tries == '0)))
                    begin
                        // report, then close the gap left by the removed entry
                        if (can_emit)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= tick_reg ? art_pkg::KIND_FAILED
                                                      : art_pkg::KIND_MATCHED;
                            msg_id_reg    <= tick_reg ? rd.id : ref_reg;
                            last_reg      <= 1'b1;
                            if (idx_p1 < used_x)
                            begin
                                addr_reg  <= idx_p1[IDX_W-1:0];
                                state_reg <= S_SH_WAIT;
                            end
                            else
                            begin
                                used_reg  <= used_reg - 1'b1;
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    else if (tick_reg && expired && !can_emit)
                    begin
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        if (tick_reg && expired)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= art_pkg::KIND_RESEND;
                            msg_id_reg    <= rd.id;
                            last_reg      <= 1'b0;
                        end
                        if (idx_p1 < used_x)
                        begin
                            idx_reg   <= idx_p1[CNT_W-1:0];
                            addr_reg  <= idx_p1[IDX_W-1:0];
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            pend_kind_reg <= tick_reg ? art_pkg::KIND_SCAN_OK
                                                      : art_pkg::KIND_UNMATCHED;
                            state_reg     <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (can_emit)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= pend_kind_reg;
                        msg_id_reg    <= pend_id_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_SH_WAIT:
                begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR:
                begin
                    idx_reg <= idx_p1[CNT_W-1:0];
                    if (idx_p2 < used_x)
                    begin
                        addr_reg  <= idx_p2[IDX_W-1:0];
                        state_reg <= S_SH_WAIT;
                    end
                    else
                    begin
                        used_reg  <= used_reg - 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == art_pkg::KIND_FAILED)) |-> last_reg)
        else $error("failed result not marked last");

    a_resend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == art_pkg::KIND_RESEND)) |-> !last_reg)
        else $error("resend result marked last");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR) |-> (idx_p1 < used_x))
        else $error("shift beyond used entries");
`endif

endmodule
